@@ src/cgst_pkg.sv @@
// package: types, constants and command structs for the colour stop table
`default_nettype none
package cgst_pkg;
  localparam int MaxStops = 16;
  localparam int IdxW = $clog2(MaxStops);
  localparam int CntW = $clog2(MaxStops + 1);

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_RD, S_ADD_CMP, S_ADD_WR, S_LK_RD, S_LK_CMP,
    S_LK_RD1, S_LK_DIV, S_LK_MUL, S_LK_SUM, S_DONE
  } state_t;

  typedef struct packed {
    logic load;       // capture input transaction
    logic clear;      // empty the table
    logic rd;         // read entry at pointer
    logic shift_wr;   // write read entry one slot up
    logic ins_wr;     // write new stop at pointer
    logic ptr_dec;
    logic ptr_inc;
    logic ptr_last;   // point at last stop
    logic ptr_zero;
    logic hold_lo;    // keep read entry as lower neighbour
    logic div_start;
    logic mul;
    logic sum;
    logic color_rd;   // result is the read colour
    logic set_full;
    logic set_empty;
    logic done;
  } cmd_t;

  typedef struct packed {
    action_t    act;
    logic       empty;
    logic       full;
    logic       ptr_zero;
    logic       rd_gt;    // read position > input position
    logic       rd_le;    // input position <= read position
    logic       div_busy;
  } stat_t;
endpackage
`default_nettype wire

@@ src/cgst_ctrl.sv @@
// controller state machine for the colour stop table
`default_nettype none
module cgst_ctrl import cgst_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire stat_t st,
  output cmd_t       cmd,
  output logic       busy
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_LK_RD;
        end
      end
      S_LK_RD: begin
        // first visit after load: decide by action
        case (st.act)
          ACT_CLEAR: begin
            cmd.clear = 1'b1;
            state_next = S_DONE;
          end
          ACT_ADD: begin
            if (st.full) begin
              cmd.set_full = 1'b1;
              state_next = S_DONE;
            end else if (st.empty) begin
              cmd.ins_wr = 1'b1;
              state_next = S_DONE;
            end else begin
              cmd.ptr_last = 1'b1;
              state_next = S_ADD_RD;
            end
          end
          ACT_LOOKUP: begin
            if (st.empty) begin
              cmd.set_empty = 1'b1;
              state_next = S_DONE;
            end else begin
              cmd.ptr_zero = 1'b1;
              state_next = S_LK_CMP;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_ADD_RD: begin
        cmd.rd = 1'b1;
        state_next = S_ADD_CMP;
      end
      S_ADD_CMP: begin
        if (st.rd_gt) begin
          cmd.shift_wr = 1'b1;
          if (st.ptr_zero) begin
            state_next = S_ADD_WR;
          end else begin
            cmd.ptr_dec = 1'b1;
            state_next = S_ADD_RD;
          end
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next = S_ADD_WR;
        end
      end
      S_ADD_WR: begin
        cmd.ins_wr = 1'b1;
        state_next = S_DONE;
      end
      S_LK_CMP: begin
        // pointer walks up; the read entry is registered and seen in S_LK_RD1
        cmd.rd = 1'b1;
        state_next = S_LK_RD1;
      end
      S_LK_RD1: begin
        if (st.ptr_zero && st.rd_le) begin
          // at or below the first stop
          cmd.color_rd = 1'b1;
          state_next = S_DONE;
        end else if (!st.ptr_zero && st.rd_gt) begin
          state_next = S_LK_DIV;
          cmd.div_start = 1'b1;
        end else if (st.full) begin
          // pointer at last stop and input at or beyond it
          cmd.color_rd = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.hold_lo = 1'b1;
          cmd.ptr_inc = 1'b1;
          state_next = S_LK_CMP;
        end
      end
      S_LK_DIV: begin
        if (!st.div_busy) state_next = S_LK_MUL;
      end
      S_LK_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_LK_SUM;
      end
      S_LK_SUM: begin
        cmd.sum = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ src/cgst_dp.sv @@
// datapath: stop memory, pointer, divider and channel blend
`default_nettype none
module cgst_dp import cgst_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  input  wire logic [1:0]  action,
  input  wire logic signed [31:0] position,
  input  wire logic [15:0] stop_red,
  input  wire logic [15:0] stop_green,
  input  wire logic [15:0] stop_blue,
  input  wire logic [15:0] stop_alpha,
  output stat_t            st,
  output logic [63:0]      color,
  output logic [1:0]       status,
  output logic [CntW-1:0]  count
);
  logic signed [31:0] pos_mem [MaxStops];
  logic [63:0]        col_mem [MaxStops];
  action_t            act;
  logic signed [31:0] in_pos;
  logic [63:0]        in_col;
  logic [CntW-1:0]    ptr;
  logic signed [31:0] rd_pos, lo_pos;
  logic [63:0]        rd_col, lo_col;
  logic               lk_top;
  logic [IdxW-1:0]    pidx;

  assign pidx = ptr[IdxW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act    <= action_t'(action);
      in_pos <= position;
      in_col <= {stop_alpha, stop_blue, stop_green, stop_red};
    end
    if (cmd.rd) begin
      rd_pos <= pos_mem[pidx];
      rd_col <= col_mem[pidx];
    end
    if (cmd.shift_wr) begin
      pos_mem[pidx + IdxW'(1)] <= rd_pos;
      col_mem[pidx + IdxW'(1)] <= rd_col;
    end else if (cmd.ins_wr) begin
      pos_mem[pidx] <= in_pos;
      col_mem[pidx] <= in_col;
    end
    if (cmd.hold_lo) begin
      lo_pos <= rd_pos;
      lo_col <= rd_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ptr   <= '0;
    end else begin
      if (cmd.load) ptr <= '0;
      if (cmd.clear) count <= '0;
      if (cmd.ins_wr) count <= count + CntW'(1);
      if (cmd.ptr_last) ptr <= count - CntW'(1);
      if (cmd.ptr_zero) ptr <= '0;
      if (cmd.ptr_dec) ptr <= ptr - CntW'(1);
      if (cmd.ptr_inc) ptr <= ptr + CntW'(1);
    end
  end

  // restoring divider: (x << 16) / d, 16 quotient bits, operands below 2^32
  logic [31:0] rem;
  logic [32:0] dvs;
  logic [15:0] quo;
  logic [31:0] diff_x;
  logic [31:0] diff_d;

  assign diff_x = 32'(in_pos - lo_pos);
  assign diff_d = 32'(rd_pos - lo_pos);

  // 48 numerator bits, one per cycle
  logic [47:0] nsh;
  logic [5:0]  ncnt;
  always_ff @(posedge clk) begin
    if (rst) begin
      ncnt <= 6'd0;
    end else if (cmd.div_start) begin
      nsh  <= {diff_x, 16'd0};
      rem  <= '0;
      dvs  <= {1'b0, diff_d};
      quo  <= '0;
      ncnt <= 6'd48;
    end else if (ncnt != 6'd0) begin
      if ({rem, nsh[47]} >= dvs) begin
        rem <= 32'({rem, nsh[47]} - dvs);
        quo <= {quo[14:0], 1'b1};
      end else begin
        rem <= {rem[30:0], nsh[47]};
        quo <= {quo[14:0], 1'b0};
      end
      nsh  <= {nsh[46:0], 1'b0};
      ncnt <= ncnt - 6'd1;
    end
  end

  // blend: four 17x17 signed products, then shift and add
  logic signed [33:0] prod [4];
  logic [63:0] blend;
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (cmd.mul)
        prod[k] <= (($signed({1'b0, rd_col[16*k +: 16]})
                   - $signed({1'b0, lo_col[16*k +: 16]})) * $signed({1'b0, quo}));
    end
  end
  always_comb begin
    for (int k = 0; k < 4; k++)
      blend[16*k +: 16] = 16'(lo_col[16*k +: 16] + 16'(prod[k] >>> 16));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      color  <= '0;
      status <= ST_OK;
    end
    if (cmd.set_full)  status <= ST_FULL;
    if (cmd.set_empty) status <= ST_EMPTY;
    if (cmd.color_rd)  color <= rd_col;
    if (cmd.sum)       color <= blend;
  end

  assign lk_top = (ptr == count - CntW'(1));
  always_comb begin
    st.act      = act;
    st.empty    = (count == '0);
    st.full     = (act == ACT_ADD) ? (count == CntW'(MaxStops)) : lk_top;
    st.ptr_zero = (ptr == '0);
    st.rd_gt    = (rd_pos > in_pos);
    st.rd_le    = (in_pos <= rd_pos) ? 1'b1 : 1'b0;
    st.div_busy = (ncnt != 6'd0);
  end
endmodule
`default_nettype wire

@@ src/color_gradient_stop_table_top.sv @@
// top level of the colour stop table
// clear, empty lookup, first add and dropped add finish without walking the stops;
// add shifts stops up from the last one; lookup walks up from the first, and between two stops divides to blend
// throughput: one transaction at a time, busy high through the strobe, next accept in the cycle after it
// the insert shift, the stop walk and the 48-step restoring divider set how long each one takes
// reset clears the stop count and the controller; the receiver cannot stall
`default_nettype none
module color_gradient_stop_table_top import cgst_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action,
  input  wire logic signed [31:0] position,
  input  wire logic [15:0] stop_red,
  input  wire logic [15:0] stop_green,
  input  wire logic [15:0] stop_blue,
  input  wire logic [15:0] stop_alpha,
  output logic             done,
  output logic [15:0]      out_red,
  output logic [15:0]      out_green,
  output logic [15:0]      out_blue,
  output logic [15:0]      out_alpha,
  output logic [1:0]       result_status,
  output logic [4:0]       stops_held
);
  cmd_t  cmd;
  stat_t st;
  logic [63:0] color;
  logic [1:0]  status;
  logic [CntW-1:0] count;

  cgst_ctrl u_ctrl (.clk, .rst, .start, .st, .cmd, .busy);
  cgst_dp u_dp (.clk, .rst, .cmd, .action, .position, .stop_red, .stop_green,
    .stop_blue, .stop_alpha, .st, .color, .status, .count);

  assign done = cmd.done;
  assign out_red   = color[15:0];
  assign out_green = color[31:16];
  assign out_blue  = color[47:32];
  assign out_alpha = color[63:48];
  assign result_status = status;
  assign stops_held = 5'(count);

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(MaxStops)) else $error("stop count over capacity");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result strobe while idle");
  a_full_keep: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FULL |-> count == CntW'(MaxStops))
    else $error("drop reported with room left");
endmodule
`default_nettype wire

@@ test/cgst_checker.sv @@
// checker: predicts each colour stop table result and compares it with the block
`timescale 1ns / 100ps
`default_nettype none
module cgst_checker import cgst_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  action,
  input  wire logic [31:0] position,
  input  wire logic [15:0] stop_red,
  input  wire logic [15:0] stop_green,
  input  wire logic [15:0] stop_blue,
  input  wire logic [15:0] stop_alpha,
  input  wire logic        done,
  input  wire logic [15:0] out_red,
  input  wire logic [15:0] out_green,
  input  wire logic [15:0] out_blue,
  input  wire logic [15:0] out_alpha,
  input  wire logic [1:0]  result_status,
  input  wire logic [4:0]  stops_held,
  output int               fail_count,
  output int               pending
);
  typedef struct packed {
    logic [15:0] r, g, b, a;
  } rgba_t;

  typedef struct packed {
    rgba_t      color;
    status_t    status;
    logic [4:0] held;
  } answer_t;

  logic signed [31:0] grad_pos[MaxStops];
  rgba_t              grad_col[MaxStops];
  int                 grad_count;
  answer_t            answers_due[$];

  assign pending = answers_due.size();

  function automatic logic [15:0] mix(logic [15:0] c0, logic [15:0] c1, longint frac);
    longint prod;
    longint q;
    prod = (longint'(c1) - longint'(c0)) * frac;
    if (prod >= 0) q = prod / 65536;
    else q = -((-prod + 65535) / 65536);
    return 16'(longint'(c0) + q);
  endfunction

  function automatic rgba_t color_at(logic signed [31:0] p);
    longint s0, s1, frac;
    rgba_t res;
    int last;
    last = grad_count - 1;
    if (grad_count == 1 || p <= grad_pos[0]) return grad_col[0];
    if (p >= grad_pos[last]) return grad_col[last];
    for (int i = 1; i < grad_count; i++) begin
      if (p < grad_pos[i]) begin
        s0 = longint'(grad_pos[i-1]);
        s1 = longint'(grad_pos[i]);
        frac = ((longint'(p) - s0) * 65536) / (s1 - s0);
        if (frac > 65535) frac = 65535;
        res.r = mix(grad_col[i-1].r, grad_col[i].r, frac);
        res.g = mix(grad_col[i-1].g, grad_col[i].g, frac);
        res.b = mix(grad_col[i-1].b, grad_col[i].b, frac);
        res.a = mix(grad_col[i-1].a, grad_col[i].a, frac);
        return res;
      end
    end
    return grad_col[last];
  endfunction

  task automatic predict_gradient(action_t act, logic signed [31:0] p, rgba_t c);
    answer_t ans;
    int j;
    ans = '0;
    ans.status = ST_OK;
    case (act)
      ACT_CLEAR: grad_count = 0;
      ACT_ADD: begin
        if (grad_count >= MaxStops) ans.status = ST_FULL;
        else begin
          j = grad_count;
          while (j > 0 && grad_pos[j-1] > p) begin
            grad_pos[j] = grad_pos[j-1];
            grad_col[j] = grad_col[j-1];
            j--;
          end
          grad_pos[j] = p;
          grad_col[j] = c;
          grad_count++;
        end
      end
      ACT_LOOKUP: begin
        if (grad_count == 0) ans.status = ST_EMPTY;
        else ans.color = color_at(p);
      end
      default: ;
    endcase
    ans.held = 5'(grad_count);
    answers_due.push_back(ans);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    answer_t exp_ans;
    if (rst) begin
      grad_count = 0;
      fail_count = 0;
      answers_due.delete();
    end else begin
      if (done) begin
        if (answers_due.size() == 0) begin
          report("unexpected transaction", 0, 0);
        end else begin
          exp_ans = answers_due.pop_front();
          if (out_red !== exp_ans.color.r) report("out_red", out_red, exp_ans.color.r);
          if (out_green !== exp_ans.color.g) report("out_green", out_green, exp_ans.color.g);
          if (out_blue !== exp_ans.color.b) report("out_blue", out_blue, exp_ans.color.b);
          if (out_alpha !== exp_ans.color.a) report("out_alpha", out_alpha, exp_ans.color.a);
          if (result_status !== exp_ans.status)
            report("result_status", result_status, exp_ans.status);
          if (stops_held !== exp_ans.held) report("stops_held", stops_held, exp_ans.held);
        end
      end
      if (start && !busy)
        predict_gradient(action_t'(action), position,
                         {stop_red, stop_green, stop_blue, stop_alpha});
    end
  end
endmodule
`default_nettype wire

@@ test/tb_color_gradient_stop_table_top.sv @@
// testbench top: drives transactions into the colour stop table and gives the verdict
`timescale 1ns / 100ps
`default_nettype none
module tb_color_gradient_stop_table_top;
  import cgst_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [1:0]  action = ACT_CLEAR;
  logic [31:0] position = '0;
  logic [15:0] stop_red = '0, stop_green = '0, stop_blue = '0, stop_alpha = '0;
  logic        done;
  logic [15:0] out_red, out_green, out_blue, out_alpha;
  logic [1:0]  result_status;
  logic [4:0]  stops_held;
  int          fail_count;
  int          pending;

  always #5 clk = ~clk;

  color_gradient_stop_table_top DUT (.*);
  cgst_checker u_checker (.*);

  task automatic send(action_t act, logic [31:0] p, logic [63:0] c, bit may_pause = 1);
    int gap;
    gap = may_pause ? $urandom_range(0, 6) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk);
    action = act;
    position = p;
    {stop_red, stop_green, stop_blue, stop_alpha} = c;
    start = 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start = 0;
  endtask

  function automatic logic [63:0] rand_color();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom();
      3: return 32'($signed($urandom_range(0, 40)) - 20) <<< 14;
      default: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
    endcase
  endfunction

  task automatic drain();
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int n;
    int kind;
    repeat (12) @(negedge clk);
    rst = 0;
    // directed: empty, single stop, extremes, duplicates, full table, unused code
    send(ACT_LOOKUP, 32'h0, '0);
    send(ACT_ADD, 32'h0001_0000, 64'hFFFF_0000_8000_FFFF);
    send(ACT_LOOKUP, 32'h8000_0000, '0);
    send(ACT_ADD, 32'h8000_0000, 64'h0000_FFFF_1234_0000);
    send(ACT_ADD, 32'h7FFF_FFFF, '1);
    send(ACT_ADD, 32'h0001_0000, 64'h0);
    send(ACT_LOOKUP, 32'h0000_8000, '0);
    send(ACT_LOOKUP, 32'h7FFF_FFFF, '0);
    send(ACT_LOOKUP, 32'h0001_0000, '0);
    send(ACT_LOOKUP, 32'h4000_0000, '0);
    send(ACT_LOOKUP, 32'hC000_0000, '0);
    send(ACT_NONE, 32'hFFFF_FFFF, '1);
    for (int i = 0; i < 13; i++) send(ACT_ADD, rand_pos(), rand_color(), 0);
    send(ACT_ADD, 32'h0, '1);
    send(ACT_LOOKUP, 32'h0, '0);
    send(ACT_CLEAR, '1, '1);
    drain();
    // random: adds and, mostly, lookups, with some noise from clears and unused codes
    n = 0;
    while (n < 1800) begin
      kind = $urandom_range(0, 99);
      if (kind < 4) send(ACT_CLEAR, $urandom(), rand_color());
      else if (kind < 40) send(ACT_ADD, rand_pos(), rand_color());
      else if (kind < 97) send(ACT_LOOKUP, rand_pos(), rand_color());
      else send(ACT_NONE, $urandom(), rand_color());
      n++;
      if (n % 500 == 0) drain();
    end
    drain();
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
src/cgst_pkg.sv
src/cgst_ctrl.sv
src/cgst_dp.sv
src/color_gradient_stop_table_top.sv
test/cgst_checker.sv
test/tb_color_gradient_stop_table_top.sv
